// ===== design/adpcm_block_decoder_macros.svh =====
// Assertion macros for the ADPCM block decoder.
// Included by the controller and datapath; no other dependencies.
`ifndef ADPCM_BLOCK_DECODER_MACROS_SVH
`define ADPCM_BLOCK_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ABD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ABD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ABD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ABD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/adpcm_pkg.sv =====
// Shared constants, types and coefficient tables for the ADPCM block decoder.
// No dependencies.
package adpcm_pkg;

	localparam int WORD_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int NIB_W    = 4;
	localparam int SHIFT_W  = 4;
	localparam int FILT_W   = 4;
	localparam int POS_W    = 3;
	localparam int NSEL_W   = 2;
	localparam int COEF_W   = 8;

	localparam logic [NSEL_W-1:0] LAST_NIB   = 2'd3;
	localparam logic [POS_W-1:0]  POS_HEADER = 3'd0;
	localparam logic [POS_W-1:0]  POS_FINAL  = 3'd7;
	localparam logic [FILT_W-1:0] FILTER_MAX = 4'd4;

	localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

	// controller -> datapath
	typedef struct packed {
		logic              load_hdr;   // latch shift and filter from the word
		logic              load_word;  // latch a data word
		logic              clear;      // zero the two-sample history
		logic              step;       // produce one sample into the output reg
		logic [NSEL_W-1:0] nib_sel;    // nibble of the data word for this step
		logic              last_nib;   // fourth sample of the word
		logic              final_word; // word 7 of the block
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // output register can take a sample this cycle
	} stat_t;

	function automatic logic signed [COEF_W-1:0] coef_first(input logic [FILT_W-1:0] f);
		logic signed [COEF_W-1:0] c;
		case (f)
			4'd1:    c = 8'sd60;
			4'd2:    c = 8'sd115;
			4'd3:    c = 8'sd98;
			4'd4:    c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_second(input logic [FILT_W-1:0] f);
		logic signed [COEF_W-1:0] c;
		case (f)
			4'd2:    c = -8'sd52;
			4'd3:    c = -8'sd55;
			4'd4:    c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

// ===== design/adpcm_ctrl.sv =====
// Controller for the ADPCM block decoder: block position, nibble sequencing
// and input handshake. Depends on adpcm_pkg and the assertion macros header.
`include "adpcm_block_decoder_macros.svh"

module adpcm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  clear_in,
	input  adpcm_pkg::stat_t      stat,
	output adpcm_pkg::cmd_t       cmd
);
	import adpcm_pkg::*;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t            state_q;
	logic [NSEL_W-1:0] nib_q;
	logic [POS_W-1:0]  pos_q;    // position of the next word to accept
	logic              final_q;  // word in flight is the last of its block
	logic              step;
	logic              last_step;
	logic              accept;

	assign step      = (state_q == ST_RUN) && stat.out_free;
	assign last_step = step && (nib_q == LAST_NIB);
	// next word may enter on the same edge as the last sample of the current one
	assign s_tready  = (state_q == ST_IDLE) || last_step;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		cmd            = '0;
		cmd.clear      = accept && clear_in;
		cmd.load_hdr   = accept && (pos_q == POS_HEADER);
		cmd.load_word  = accept && (pos_q != POS_HEADER);
		cmd.step       = step;
		cmd.nib_sel    = nib_q;
		cmd.last_nib   = (nib_q == LAST_NIB);
		cmd.final_word = final_q && (nib_q == LAST_NIB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nib_q   <= '0;
			pos_q   <= POS_HEADER;
			final_q <= 1'b0;
		end else begin
			if (step)
				nib_q <= nib_q + 1'b1;
			if (last_step)
				state_q <= ST_IDLE;
			if (accept) begin
				pos_q <= pos_q + 1'b1;  // 7 wraps back to header
				if (pos_q != POS_HEADER) begin
					state_q <= ST_RUN;
					nib_q   <= '0;
					final_q <= (pos_q == POS_FINAL);
				end
			end
		end
	end

	`ABD_ASSERT_NXT(a_data_starts_run, clk, arst_n, accept && (pos_q != POS_HEADER), (state_q == ST_RUN) && (nib_q == '0), "data word did not start a run")
	`ABD_ASSERT_IMP(a_busy_no_ready, clk, arst_n, (state_q == ST_RUN) && (nib_q != LAST_NIB), !s_tready, "ready raised mid-word")
	`ABD_ASSERT_NXT(a_hdr_no_run, clk, arst_n, accept && (pos_q == POS_HEADER), (state_q == ST_IDLE) && (pos_q == 3'd1), "header word started a run")

endmodule

// ===== design/adpcm_dp.sv =====
// Datapath for the ADPCM block decoder: header and word registers, sample
// history, predictor, saturation and output register. Depends on adpcm_pkg.
`include "adpcm_block_decoder_macros.svh"

module adpcm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [adpcm_pkg::WORD_W-1:0]         word_in,
	input  adpcm_pkg::cmd_t                      cmd,
	output adpcm_pkg::stat_t                     stat,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic signed [adpcm_pkg::SAMPLE_W-1:0] sample,
	output logic                                 last_of_word,
	output logic                                 block_end,
	output logic                                 bad_filter
);
	import adpcm_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int PSUM_W = PROD_W + 1;
	localparam int PRED_W = PSUM_W - 6;
	localparam int SUM_W  = PRED_W + 1;

	logic [WORD_W-1:0]          word_q;
	logic [SHIFT_W-1:0]         shift_q;
	logic [FILT_W-1:0]          filter_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] older_q;
	logic                       valid_q;

	logic [NIB_W-1:0]           nib;
	logic signed [SAMPLE_W-1:0] nib_ext;
	logic signed [SAMPLE_W-1:0] scaled;
	logic signed [COEF_W-1:0]   c0;
	logic signed [COEF_W-1:0]   c1;
	logic signed [PROD_W-1:0]   p0;
	logic signed [PROD_W-1:0]   p1;
	logic signed [PSUM_W-1:0]   psum;
	logic signed [PRED_W-1:0]   pred;
	logic signed [SUM_W-1:0]    total;
	logic signed [SAMPLE_W-1:0] sat;

	assign nib     = word_q[{cmd.nib_sel, 2'b00} +: NIB_W];
	assign nib_ext = {nib, 12'b0};
	assign scaled  = nib_ext >>> shift_q;

	assign c0   = coef_first(filter_q);
	assign c1   = coef_second(filter_q);
	assign p0   = PROD_W'(c0) * PROD_W'(prev_q);
	assign p1   = PROD_W'(c1) * PROD_W'(older_q);
	assign psum = PSUM_W'(p0) + PSUM_W'(p1) + PSUM_W'(32);
	assign pred = PRED_W'(psum >>> 6);
	assign total = SUM_W'(scaled) + SUM_W'(pred);

	always_comb begin
		if (total > SUM_W'(SAT_MAX))
			sat = SAT_MAX;
		else if (total < SUM_W'(SAT_MIN))
			sat = SAT_MIN;
		else
			sat = total[SAMPLE_W-1:0];
	end

	assign stat.out_free = !valid_q || m_tready;
	assign m_tvalid      = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			filter_q <= '0;
			prev_q   <= '0;
			older_q  <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.load_hdr) begin
				shift_q  <= word_in[SHIFT_W-1:0];
				filter_q <= word_in[SHIFT_W +: FILT_W];
			end
			if (cmd.step) begin
				prev_q  <= sat;
				older_q <= prev_q;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			// a clear belongs to the incoming word, so it wins over the last step
			if (cmd.clear) begin
				prev_q  <= '0;
				older_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word)
			word_q <= word_in;
		if (cmd.step) begin
			sample       <= sat;
			last_of_word <= cmd.last_nib;
			block_end    <= cmd.final_word;
			bad_filter   <= (filter_q > FILTER_MAX);
		end
	end

	`ABD_ASSERT_NXT(a_step_fills_out, clk, arst_n, cmd.step, m_tvalid, "step did not fill output")
	`ABD_ASSERT_NXT(a_clear_zeroes, clk, arst_n, cmd.clear, (prev_q == '0) && (older_q == '0), "history not cleared")
	`ABD_ASSERT_NXT(a_out_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "output item dropped while stalled")

endmodule

// ===== design/adpcm_block_decoder.sv =====
// ADPCM block decoder top level: 4-bit SPU-style ADPCM to 16-bit PCM.
// Depends on adpcm_pkg, adpcm_ctrl and adpcm_dp.
//
// Usage:
//  - Input channel (s_*): one item per 16-bit block word. A block is eight
//    items: the header (shift in bits 3..0, filter in bits 7..4), then seven
//    data words. s_tuser carries clear_history, which zeroes the two-sample
//    predictor history before that word is used (header words included).
//  - Output channel (m_*): four sample items per data word, low nibble first.
//    Header words produce no output.
//  - Timing: an accepted data word is held in the word register, and each of
//    its samples is registered in the output register. While that register
//    can take a sample, the predictor loop produces one sample per cycle; the
//    next word is taken on the edge that emits the fourth sample of this one.
//  - Stall: the single output register holds its item while m_tready is low;
//    sample production pauses until it drains. Headers and one more data word
//    are still taken; s_tready stays low until that word's last sample is made.
//  - Reset (arst_n low): block position returns to header, shift/filter and
//    history clear to zero, no output item is pending.
module adpcm_block_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [adpcm_pkg::WORD_W-1:0]          s_tdata,  // [15:0] word
	input  logic                                  s_tuser,  // [0] clear_history
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic signed [adpcm_pkg::SAMPLE_W-1:0] m_tdata,  // [15:0] sample
	output logic                                  m_tlast,  // block_end
	output logic [1:0]                            m_tuser   // [0] last_of_word, [1] bad_filter
);
	import adpcm_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  last_of_word;
	logic  bad_filter;

	adpcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.clear_in (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	adpcm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_in      (s_tdata),
		.cmd          (cmd),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.sample       (m_tdata),
		.last_of_word (last_of_word),
		.block_end    (m_tlast),
		.bad_filter   (bad_filter)
	);

	assign m_tuser = {bad_filter, last_of_word};

endmodule

// ===== test/adpcm_block_decoder_checker.sv =====
// Watches the word and sample streams of adpcm_block_decoder and predicts every sample.
// Depends on adpcm_pkg for the block position codes and the filter limit.
module adpcm_block_decoder_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [15:0]        s_tdata,  // [15:0] word
	input  logic               s_tuser,  // [0] clear_history
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic signed [15:0] m_tdata,  // [15:0] sample
	input  logic               m_tlast,  // block_end
	input  logic [1:0]         m_tuser,  // [0] last_of_word, [1] bad_filter
	output int                 mismatches,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import adpcm_pkg::*;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_of_word;
		logic               block_end;
		logic               bad_filter;
	} pcm_item_t;

	// predictor taps per filter id; ids above 4 predict nothing
	localparam int TAP_NEW [16] = '{0, 60, 115, 98, 122, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam int TAP_OLD [16] = '{0, 0, -52, -55, -60, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	pcm_item_t          expected_samples[$];
	logic [2:0]         word_pos;
	logic [3:0]         hdr_shift;
	logic [3:0]         hdr_filter;
	logic signed [15:0] prev_smp;
	logic signed [15:0] older_smp;

	function automatic logic signed [15:0] decode_nibble(input logic [3:0] nib,
			input logic [3:0] sh, input logic [3:0] fid,
			input logic signed [15:0] p1, input logic signed [15:0] p2);
		int pred;
		int delta;
		int total;
		pred  = (TAP_NEW[fid] * int'(p1) + TAP_OLD[fid] * int'(p2) + 32) >>> 6;
		delta = (int'($signed(nib)) * 4096) >>> sh;
		total = delta + pred;
		if (total > 32767)
			total = 32767;
		else if (total < -32768)
			total = -32768;
		return total[15:0];
	endfunction

	task automatic absorb_word(input logic [15:0] w, input logic clr);
		pcm_item_t          item;
		logic signed [15:0] s;
		if (clr) begin
			prev_smp  = '0;
			older_smp = '0;
		end
		if (word_pos == POS_HEADER) begin
			hdr_shift  = w[3:0];
			hdr_filter = w[7:4];
		end else begin
			for (int k = 0; k < 4; k++) begin
				s = decode_nibble(w[4*k +: 4], hdr_shift, hdr_filter, prev_smp, older_smp);
				older_smp = prev_smp;
				prev_smp  = s;
				item.sample       = s;
				item.last_of_word = (k == 3);
				item.block_end    = (k == 3) && (word_pos == POS_FINAL);
				item.bad_filter   = (hdr_filter > FILTER_MAX);
				expected_samples.push_back(item);
			end
		end
		word_pos = word_pos + 3'd1;
	endtask

	task automatic check_sample();
		pcm_item_t want;
		if (expected_samples.size() == 0) begin
			$display("%0t: unexpected sample %0d", $time, m_tdata);
			mismatches++;
		end else begin
			want = expected_samples.pop_front();
			if (m_tdata !== want.sample) begin
				$display("%0t: sample expected %0d got %0d", $time, want.sample, m_tdata);
				mismatches++;
			end
			if (m_tuser[0] !== want.last_of_word) begin
				$display("%0t: last_of_word expected %b got %b", $time,
					want.last_of_word, m_tuser[0]);
				mismatches++;
			end
			if (m_tlast !== want.block_end) begin
				$display("%0t: block_end expected %b got %b", $time, want.block_end, m_tlast);
				mismatches++;
			end
			if (m_tuser[1] !== want.bad_filter) begin
				$display("%0t: bad_filter expected %b got %b", $time,
					want.bad_filter, m_tuser[1]);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos   = POS_HEADER;
			hdr_shift  = '0;
			hdr_filter = '0;
			prev_smp   = '0;
			older_smp  = '0;
			mismatches = 0;
			expected_samples.delete();
			pending <= 0;
		end else begin
			// a sample always leaves on a later edge than its word enters, so check first
			if (m_tvalid && m_tready)
				check_sample();
			if (s_tvalid && s_tready)
				absorb_word(s_tdata, s_tuser);
			pending <= expected_samples.size();
		end
	end

endmodule

// ===== test/adpcm_block_decoder_tb.sv =====
// Stimulus and verdict for adpcm_block_decoder: directed blocks, then random blocks.
// Depends on adpcm_pkg, adpcm_block_decoder and adpcm_block_decoder_checker.
module adpcm_block_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BLOCKS = 43;   // plus three directed blocks, ~370 words
	localparam int STALL_LIMIT   = 1500; // cycles with no transfer on either side
	localparam int LONG_HOLD     = 250;  // receiver hold-off that backs up the input
	localparam int TAIL_CYCLES   = 12;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata = '0;  // [15:0] word
	logic               s_tuser = 1'b0; // [0] clear_history
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic signed [15:0] m_tdata;       // [15:0] sample
	logic               m_tlast;       // block_end
	logic [1:0]         m_tuser;       // [0] last_of_word, [1] bad_filter

	int mismatches;
	int pending;
	int idle_cycles = 0;
	bit tx_idle = 1'b1;

	always #5 clk = ~clk;

	adpcm_block_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	adpcm_block_decoder_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Offer one word. The gap in front of it is drawn per item unless the
	// current block runs back to back. With no gap, valid simply stays high
	// and only the payload changes, so valid never toggles within one step.
	task automatic send_word(input logic [15:0] w, input logic clr);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= clr;
		do @(posedge clk); while (!s_tready);
	endtask

	// Header layout: loop flags in the upper byte (ignored), filter, shift.
	task automatic send_block(input logic [7:0] flags, input logic [3:0] filt,
			input logic [3:0] sh, input logic [7:0] clr_mask, input logic [15:0] data [7]);
		send_word({flags, filt, sh}, clr_mask[0]);
		for (int i = 0; i < 7; i++)
			send_word(data[i], clr_mask[i+1]);
	endtask

	// Sample sink: random hold-off per item, with stretches of full rate.
	// Once, after enough samples, it holds off long enough that the output
	// register fills and the decoder has to stop taking words.
	initial begin
		int  got;
		int  gap;
		bit  rx_idle;
		bit  held;
		got     = 0;
		rx_idle = 1'b1;
		held    = 1'b0;
		@(posedge arst_n);
		forever begin
			if (got % 28 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
			if (!held && got == 120) begin
				held = 1'b1;
				gap  = LONG_HOLD;
			end else begin
				gap = rx_idle ? $urandom_range(0, 9) : 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got++;
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [15:0] data [7];
		logic [3:0]  filt;
		logic [7:0]  clr_mask;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed 1: strongest filter at shift 0, runs of +7 then -8 nibbles,
		// driving the output into both saturation limits.
		data = '{16'h7777, 16'h7777, 16'h7777, 16'h8888, 16'h8888, 16'h8888, 16'h0000};
		send_block(8'h00, 4'd4, 4'd0, 8'h01, data);

		// Directed 2: all-ones header (loop flags set, unknown filter 15,
		// largest shift) with a clear on the header itself; extreme nibbles.
		data = '{16'hFFFF, 16'h1234, 16'h8001, 16'h7FFE, 16'hA5A5, 16'h5A5A, 16'h0F0F};
		send_block(8'hFF, 4'd15, 4'd15, 8'h01, data);

		// Directed 3: filter 2 at shift 13 so small nibbles fall to 0 or -1,
		// and a clear arriving in the middle of the block.
		data = '{16'h7F80, 16'h1357, 16'h9BDF, 16'h0000, 16'hFFFF, 16'h8421, 16'h4812};
		send_block(8'h00, 4'd2, 4'd13, 8'h08, data);

		// Random blocks: mostly valid filters, a quarter with unknown ids,
		// occasional clears, and now and then a saturating run of nibbles.
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			filt    = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15))
			                                      : 4'($urandom_range(0, 4));
			for (int i = 0; i < 7; i++) begin
				case ($urandom_range(0, 9))
					0:       data[i] = 16'h7777;
					1:       data[i] = 16'h8888;
					default: data[i] = 16'($urandom());
				endcase
			end
			clr_mask = '0;
			for (int i = 0; i < 8; i++)
				clr_mask[i] = ($urandom_range(0, 15) == 0);
			send_block(8'($urandom()), filt, 4'($urandom_range(0, 15)), clr_mask, data);
		end

		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;

		// Drain: pending is registered, so look only after the next edge.
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
